[design/msgpk_pkg.sv]
// ----------------------------------------------------------------------------
// msgpk_pkg
// Shared types, codes and format bytes for the MessagePack stream encoder.
// ----------------------------------------------------------------------------
package msgpk_pkg;

    localparam int POS_W       = 17;
    localparam int DEPTH_W     = 8;
    localparam int LEN_W       = 16;
    localparam int VALUE_W     = 64;
    localparam int BYTE_W      = 8;
    localparam int MAX_BYTES   = 9;
    localparam int CNT_W       = 4;
    localparam int BUFFER_BYTES = 65536;

    localparam logic [POS_W-1:0]   RESET_BUFFER_SIZE = POS_W'(65536);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX         = '1;

    typedef logic [BYTE_W-1:0] t_byte;

    typedef enum logic [3:0] {
        OP_NIL      = 4'd0,
        OP_TRUE     = 4'd1,
        OP_FALSE    = 4'd2,
        OP_UINT     = 4'd3,
        OP_SINT     = 4'd4,
        OP_MAP      = 4'd5,
        OP_ENDMAP   = 4'd6,
        OP_ARRAY    = 4'd7,
        OP_ENDARRAY = 4'd8,
        OP_STR      = 4'd9,
        OP_STRBYTE  = 4'd10,
        OP_SAVE     = 4'd11,
        OP_RESTORE  = 4'd12,
        OP_RESTART  = 4'd13
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_NO_ROOM   = 2'd2,
        ST_UNDERFLOW = 2'd3
    } t_status;

    localparam t_byte TAG_NIL      = 8'hC0;
    localparam t_byte TAG_FALSE    = 8'hC2;
    localparam t_byte TAG_TRUE     = 8'hC3;
    localparam t_byte TAG_UINT8    = 8'hCC;
    localparam t_byte TAG_UINT16   = 8'hCD;
    localparam t_byte TAG_UINT32   = 8'hCE;
    localparam t_byte TAG_UINT64   = 8'hCF;
    localparam t_byte TAG_INT8     = 8'hD0;
    localparam t_byte TAG_INT16    = 8'hD1;
    localparam t_byte TAG_INT32    = 8'hD2;
    localparam t_byte TAG_INT64    = 8'hD3;
    localparam t_byte TAG_FIXMAP   = 8'h80;
    localparam t_byte TAG_FIXARRAY = 8'h90;
    localparam t_byte TAG_FIXSTR   = 8'hA0;
    localparam t_byte TAG_MAP16    = 8'hDE;
    localparam t_byte TAG_ARRAY16  = 8'hDC;
    localparam t_byte TAG_STR16    = 8'hDA;

endpackage

[design/msgpack_stream_encoder.sv]
// ----------------------------------------------------------------------------
// msgpack_stream_encoder
// Encodes one command per input transfer into MessagePack bytes, one byte
// per output transfer, with position, nesting depth and string body tracking.
//
//  channel   dir  tdata                         tuser                 tlast
//  s_axis    in   [63:0] value, [71:64] byte    [3:0] op              -
//  m_axis    out  [7:0] byte, [24:8] position   [0] valid, [2:1] stat last
//  cfg       in   i_cfg_wr_data = buffer_size   -                     -
//
// An item is held in the input register and then leaves the output shift
// register one result per output transfer, until all of its results are sent.
// The next item is encoded in the cycle its predecessor's last result leaves.
// Reset is synchronous; it clears position, depths and string state.
// A stall on m_axis holds the current result and backs up into s_axis.
// ----------------------------------------------------------------------------
module msgpack_stream_encoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [71:0]                   s_axis_tdata,  // value, data_byte
    input  logic [3:0]                    s_axis_tuser,  // op
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [31:0]                   m_axis_tdata,  // out_byte, position, pad
    output logic [2:0]                    m_axis_tuser,  // byte_valid, status
    output logic                          m_axis_tlast,
    input  logic                          i_cfg_wr_en,
    input  logic [msgpk_pkg::POS_W-1:0]   i_cfg_wr_data
);

    localparam int POS_W   = msgpk_pkg::POS_W;
    localparam int DEPTH_W = msgpk_pkg::DEPTH_W;
    localparam int LEN_W   = msgpk_pkg::LEN_W;
    localparam int VALUE_W = msgpk_pkg::VALUE_W;
    localparam int NB      = msgpk_pkg::MAX_BYTES;
    localparam int CNT_W   = msgpk_pkg::CNT_W;

    logic [POS_W-1:0]           r_buffer_size;
    logic [POS_W-1:0]           r_write_pos;
    logic [DEPTH_W-1:0]         r_map_depth;
    logic [DEPTH_W-1:0]         r_array_depth;
    logic [LEN_W-1:0]           r_string_left;
    logic                       r_string_drop;

    logic                       r_in_valid;
    logic [3:0]                 r_op;
    logic [VALUE_W-1:0]         r_value;
    msgpk_pkg::t_byte           r_data;

    logic                       r_out_valid;
    msgpk_pkg::t_byte           r_bytes [NB];
    logic [CNT_W-1:0]           r_nbytes;
    logic                       r_closing;
    msgpk_pkg::t_status         r_status;
    logic [POS_W-1:0]           r_pos;
    logic [POS_W-1:0]           r_final_pos;

    logic [POS_W-1:0]           n_write_pos;
    logic [DEPTH_W-1:0]         n_map_depth;
    logic [DEPTH_W-1:0]         n_array_depth;
    logic [LEN_W-1:0]           n_string_left;
    logic                       n_string_drop;

    logic [POS_W-1:0]           buf_end;
    logic                       want_write;
    msgpk_pkg::t_byte           tag;
    logic [CNT_W-1:0]           plen;
    logic [VALUE_W-1:0]         pay;
    msgpk_pkg::t_byte           bytes [NB];
    logic                       fit1;
    logic                       fit2;
    logic                       ok1;
    logic                       ok2;
    logic [CNT_W-1:0]           nbytes;
    logic [POS_W-1:0]           pos_after;
    logic                       body_fits;
    logic                       count_big;
    msgpk_pkg::t_status         status;

    logic                       cur_last;
    logic                       m_fire;
    logic                       s_fire;
    logic                       out_free;
    logic                       load;

    assign buf_end = (32'(r_buffer_size) > msgpk_pkg::BUFFER_BYTES)
                   ? POS_W'(msgpk_pkg::BUFFER_BYTES) : r_buffer_size;
    assign count_big = (r_value[VALUE_W-1:LEN_W] != '0);

    // Select the type byte and payload length for the command.
    always_comb begin
        want_write = 1'b0;
        tag        = r_data;
        plen       = '0;
        case (r_op)
            msgpk_pkg::OP_NIL: begin
                want_write = 1'b1;
                tag        = msgpk_pkg::TAG_NIL;
            end
            msgpk_pkg::OP_TRUE: begin
                want_write = 1'b1;
                tag        = msgpk_pkg::TAG_TRUE;
            end
            msgpk_pkg::OP_FALSE: begin
                want_write = 1'b1;
                tag        = msgpk_pkg::TAG_FALSE;
            end
            msgpk_pkg::OP_UINT: begin
                want_write = 1'b1;
                if (r_value[63:7] == '0) begin
                    tag = r_value[7:0];
                end else if (r_value[63:8] == '0) begin
                    tag  = msgpk_pkg::TAG_UINT8;
                    plen = CNT_W'(1);
                end else if (r_value[63:16] == '0) begin
                    tag  = msgpk_pkg::TAG_UINT16;
                    plen = CNT_W'(2);
                end else if (r_value[63:32] == '0) begin
                    tag  = msgpk_pkg::TAG_UINT32;
                    plen = CNT_W'(4);
                end else begin
                    tag  = msgpk_pkg::TAG_UINT64;
                    plen = CNT_W'(8);
                end
            end
            msgpk_pkg::OP_SINT: begin
                want_write = 1'b1;
                if (r_value[63:7] == '0 || r_value[63:5] == '1) begin
                    tag = r_value[7:0];
                end else if (r_value[63:7] == '1) begin
                    tag  = msgpk_pkg::TAG_INT8;
                    plen = CNT_W'(1);
                end else if (r_value[63:15] == '0 || r_value[63:15] == '1) begin
                    tag  = msgpk_pkg::TAG_INT16;
                    plen = CNT_W'(2);
                end else if (r_value[63:31] == '0 || r_value[63:31] == '1) begin
                    tag  = msgpk_pkg::TAG_INT32;
                    plen = CNT_W'(4);
                end else begin
                    tag  = msgpk_pkg::TAG_INT64;
                    plen = CNT_W'(8);
                end
            end
            msgpk_pkg::OP_MAP, msgpk_pkg::OP_ARRAY: begin
                want_write = !count_big;
                if (r_value[15:4] == '0) begin
                    tag = ((r_op == msgpk_pkg::OP_MAP) ? msgpk_pkg::TAG_FIXMAP
                                                       : msgpk_pkg::TAG_FIXARRAY)
                        | {4'b0, r_value[3:0]};
                end else begin
                    tag  = (r_op == msgpk_pkg::OP_MAP) ? msgpk_pkg::TAG_MAP16
                                                       : msgpk_pkg::TAG_ARRAY16;
                    plen = CNT_W'(2);
                end
            end
            msgpk_pkg::OP_STR: begin
                want_write = !count_big;
                if (r_value[15:5] == '0) begin
                    tag = msgpk_pkg::TAG_FIXSTR | {3'b0, r_value[4:0]};
                end else begin
                    tag  = msgpk_pkg::TAG_STR16;
                    plen = CNT_W'(2);
                end
            end
            msgpk_pkg::OP_STRBYTE: begin
                want_write = (r_string_left != '0) && !r_string_drop;
                tag        = r_data;
            end
            default: begin
                want_write = 1'b0;
            end
        endcase
    end

    // Lay out the payload big-endian behind the type byte.
    always_comb begin
        case (plen)
            CNT_W'(1): pay = {r_value[7:0], 56'b0};
            CNT_W'(2): pay = {r_value[15:0], 48'b0};
            CNT_W'(4): pay = {r_value[31:0], 32'b0};
            default:   pay = r_value;
        endcase
        bytes[0] = tag;
        for (int j = 0; j < NB - 1; j++) begin
            bytes[j+1] = pay[VALUE_W-1-8*j -: 8];
        end
    end

    assign fit1 = ({1'b0, r_write_pos} + 18'd1) <= {1'b0, buf_end};
    assign fit2 = ({1'b0, r_write_pos} + 18'd1 + 18'(plen)) <= {1'b0, buf_end};
    assign ok1  = want_write && fit1;
    assign ok2  = ok1 && fit2;
    assign nbytes    = !ok1 ? '0 : (ok2 ? plen + CNT_W'(1) : CNT_W'(1));
    assign pos_after = r_write_pos + POS_W'(nbytes);
    assign body_fits = ({1'b0, pos_after} + 18'(r_value[LEN_W-1:0])) <= {1'b0, buf_end};

    // Next state and status.
    always_comb begin
        n_write_pos   = pos_after;
        n_map_depth   = r_map_depth;
        n_array_depth = r_array_depth;
        n_string_left = r_string_left;
        n_string_drop = r_string_drop;
        status        = (want_write && !ok2) ? msgpk_pkg::ST_NO_ROOM : msgpk_pkg::ST_OK;
        case (r_op)
            msgpk_pkg::OP_MAP: begin
                if (count_big) begin
                    status = msgpk_pkg::ST_TOO_LARGE;
                end else if (r_map_depth != msgpk_pkg::DEPTH_MAX) begin
                    n_map_depth = r_map_depth + DEPTH_W'(1);
                end
            end
            msgpk_pkg::OP_ARRAY: begin
                if (count_big) begin
                    status = msgpk_pkg::ST_TOO_LARGE;
                end else if (r_array_depth != msgpk_pkg::DEPTH_MAX) begin
                    n_array_depth = r_array_depth + DEPTH_W'(1);
                end
            end
            msgpk_pkg::OP_ENDMAP: begin
                if (r_map_depth == '0) begin
                    status = msgpk_pkg::ST_UNDERFLOW;
                end else begin
                    n_map_depth = r_map_depth - DEPTH_W'(1);
                end
            end
            msgpk_pkg::OP_ENDARRAY: begin
                if (r_array_depth == '0) begin
                    status = msgpk_pkg::ST_UNDERFLOW;
                end else begin
                    n_array_depth = r_array_depth - DEPTH_W'(1);
                end
            end
            msgpk_pkg::OP_STR: begin
                if (count_big) begin
                    status = msgpk_pkg::ST_TOO_LARGE;
                end else begin
                    n_string_left = r_value[LEN_W-1:0];
                    n_string_drop = !(ok2 && body_fits);
                    status        = n_string_drop ? msgpk_pkg::ST_NO_ROOM
                                                  : msgpk_pkg::ST_OK;
                end
            end
            msgpk_pkg::OP_STRBYTE: begin
                if (r_string_left != '0) begin
                    n_string_left = r_string_left - LEN_W'(1);
                    n_string_drop = r_string_drop || !ok2;
                    status        = n_string_drop ? msgpk_pkg::ST_NO_ROOM
                                                  : msgpk_pkg::ST_OK;
                end
            end
            msgpk_pkg::OP_RESTORE: begin
                n_write_pos = (r_value > {{(VALUE_W-POS_W){1'b0}}, buf_end})
                            ? buf_end : r_value[POS_W-1:0];
            end
            msgpk_pkg::OP_RESTART: begin
                n_write_pos   = '0;
                n_map_depth   = '0;
                n_array_depth = '0;
                n_string_left = '0;
                n_string_drop = 1'b0;
            end
            default: begin
                n_write_pos = pos_after;
            end
        endcase
    end

    // Handshake between input register and output shift register.
    assign cur_last = (r_nbytes == '0) || (r_nbytes == CNT_W'(1) && !r_closing);
    assign m_fire   = r_out_valid && m_axis_tready;
    assign s_fire   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || (m_fire && cur_last);
    assign load     = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || load;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = cur_last;
    assign m_axis_tdata  = {7'b0,
                            (r_nbytes != '0) ? r_pos : r_final_pos,
                            (r_nbytes != '0) ? r_bytes[0] : 8'h00};
    assign m_axis_tuser  = {(r_nbytes != '0) ? msgpk_pkg::ST_OK : r_status,
                            r_nbytes != '0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_size <= msgpk_pkg::RESET_BUFFER_SIZE;
            r_write_pos   <= '0;
            r_map_depth   <= '0;
            r_array_depth <= '0;
            r_string_left <= '0;
            r_string_drop <= 1'b0;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_buffer_size <= i_cfg_wr_data;
            end
            if (s_fire) begin
                r_in_valid <= 1'b1;
            end else if (load) begin
                r_in_valid <= 1'b0;
            end
            if (load) begin
                r_out_valid   <= 1'b1;
                r_write_pos   <= n_write_pos;
                r_map_depth   <= n_map_depth;
                r_array_depth <= n_array_depth;
                r_string_left <= n_string_left;
                r_string_drop <= n_string_drop;
            end else if (m_fire && cur_last) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_op    <= s_axis_tuser;
            r_value <= s_axis_tdata[VALUE_W-1:0];
            r_data  <= s_axis_tdata[VALUE_W +: 8];
        end
        if (load) begin
            r_bytes     <= bytes;
            r_nbytes    <= nbytes;
            r_closing   <= (nbytes == '0) || (status != msgpk_pkg::ST_OK);
            r_status    <= status;
            r_pos       <= r_write_pos + POS_W'(1);
            r_final_pos <= n_write_pos;
        end else if (m_fire && r_nbytes != '0) begin
            for (int i = 0; i < NB - 1; i++) begin
                r_bytes[i] <= r_bytes[i+1];
            end
            r_bytes[NB-1] <= '0;
            r_nbytes      <= r_nbytes - CNT_W'(1);
            r_pos         <= r_pos + POS_W'(1);
        end
    end

endmodule
